/* rtl/ole_pkg.sv */
package ole_pkg;

    // default list depth
    localparam int CAPACITY_DEFAULT = 32;

    // command codes
    localparam logic [3:0] CMD_PUSH_FRONT = 4'd0;
    localparam logic [3:0] CMD_PUSH_BACK  = 4'd1;
    localparam logic [3:0] CMD_INSERT_AT  = 4'd2;
    localparam logic [3:0] CMD_POP_FRONT  = 4'd3;
    localparam logic [3:0] CMD_POP_BACK   = 4'd4;
    localparam logic [3:0] CMD_DELETE_AT  = 4'd5;
    localparam logic [3:0] CMD_FIND_VALUE = 4'd6;
    localparam logic [3:0] CMD_READ_AT    = 4'd7;
    localparam logic [3:0] CMD_COUNT      = 4'd8;
    localparam logic [3:0] CMD_PURGE      = 4'd9;

    // status codes
    localparam logic [2:0] STS_OK       = 3'd0;
    localparam logic [2:0] STS_EMPTY    = 3'd1;
    localparam logic [2:0] STS_INVALID  = 3'd2;
    localparam logic [2:0] STS_RANGE    = 3'd3;
    localparam logic [2:0] STS_NOTFOUND = 3'd4;
    localparam logic [2:0] STS_FULL     = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_PUT,
        ST_DONE
    } ole_state_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_INS,
        OP_DEL,
        OP_READ,
        OP_FIND,
        OP_PURGE
    } ole_op_t;

endpackage

/* rtl/ordered_list_engine_core.sv */
// accept to result valid: a count or an error goes straight to the done state, a read
// fetches its slot, pop or delete at a position walks from that slot to the back
// push or insert shifts the tail up from the back, then writes the new value in its slot
// find value walks the entries held, stopping early on a match; purge walks every entry
// throughput: one transaction in flight; a command is accepted only in the idle state,
// once the last result is loaded; a stalled result holds the next one in the done state
// reset: synchronous active-low aresetn empties the list, ram contents are not cleared
module ordered_list_engine_core #(
    parameter int CAPACITY = ole_pkg::CAPACITY_DEFAULT
) (
    input  logic               aclk,
    input  logic               aresetn,
    // command channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_command,
    input  logic signed [31:0] s_value,
    input  logic [5:0]         s_position,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic signed [31:0] m_result_value,
    output logic [5:0]         m_result_position,
    output logic [5:0]         m_entry_count
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    // common width for comparing a 6-bit position with the count
    localparam int WW    = CNT_W + 6;

    // sequencer and datapath registers
    ole_pkg::ole_state_t state_reg, state_next;
    ole_pkg::ole_op_t    op_reg, op_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [31:0]         val_reg, val_next;
    logic [IDX_W-1:0]    k_reg, k_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]    last_reg, last_next;
    logic                dn_reg, dn_next;
    logic                rd_more_reg, rd_more_next;
    logic                p_vld_reg, p_vld_next;
    logic [IDX_W-1:0]    p_idx_reg, p_idx_next;
    logic [CNT_W-1:0]    w_reg, w_next;
    logic                hit_reg, hit_next;
    logic [2:0]          st_reg, st_next;
    logic [31:0]         rv_reg, rv_next;
    logic [CNT_W-1:0]    rp_reg, rp_next;

    // result register
    logic                m_valid_reg, m_valid_next;
    logic [2:0]          m_status_reg, m_status_next;
    logic [31:0]         m_value_reg, m_value_next;
    logic [5:0]          m_pos_reg, m_pos_next;
    logic [5:0]          m_cnt_reg, m_cnt_next;

    // ram port
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [31:0]         wr_data;
    logic                rd_en;
    logic [31:0]         rd_data;

    // command decode
    ole_pkg::ole_op_t    dec_op;
    logic [2:0]          dec_st;
    logic [IDX_W-1:0]    dec_k;

    logic [WW-1:0]       pos_w;
    logic [WW-1:0]       cnt_w;
    logic [WW-1:0]       pos_m1;
    logic [CNT_W-1:0]    cnt_m1;
    logic                list_full;
    logic                list_empty;
    logic                accept;
    logic                walk_end;
    logic                out_load;
    logic [CNT_W+5:0]    rp_ext;
    logic [CNT_W+5:0]    cnt_ext;

    assign pos_w      = WW'(s_position);
    assign cnt_w      = WW'(cnt_reg);
    assign pos_m1     = pos_w - WW'(1);
    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign list_full  = (cnt_reg == CNT_W'(CAPACITY));
    assign list_empty = (cnt_reg == '0);

    assign s_ready  = (state_reg == ole_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    // walk is over once no read is issued and none is in flight
    assign walk_end = !rd_more_reg && !p_vld_reg;
    // result register frees up when empty or being taken this cycle
    assign out_load = (state_reg == ole_pkg::ST_DONE) && (!m_valid_reg || m_ready);

    ole_mem #(
        .DEPTH (CAPACITY),
        .AW    (IDX_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (cur_reg),
        .rd_data (rd_data)
    );

    // early status checks and the slot that the command works on
    always_comb begin
        dec_op = ole_pkg::OP_NONE;
        dec_st = ole_pkg::STS_OK;
        dec_k  = '0;
        unique case (s_command)
            ole_pkg::CMD_PUSH_FRONT: begin
                if (list_full) begin
                    dec_st = ole_pkg::STS_FULL;
                end else begin
                    dec_op = ole_pkg::OP_INS;
                end
            end
            ole_pkg::CMD_PUSH_BACK: begin
                if (list_full) begin
                    dec_st = ole_pkg::STS_FULL;
                end else begin
                    dec_op = ole_pkg::OP_INS;
                    dec_k  = cnt_reg[IDX_W-1:0];
                end
            end
            ole_pkg::CMD_INSERT_AT: begin
                priority if (s_position == '0) begin
                    dec_st = ole_pkg::STS_INVALID;
                end else if (pos_w > cnt_w + WW'(1)) begin
                    dec_st = ole_pkg::STS_RANGE;
                end else if (list_full) begin
                    dec_st = ole_pkg::STS_FULL;
                end else begin
                    dec_op = ole_pkg::OP_INS;
                    dec_k  = pos_m1[IDX_W-1:0];
                end
            end
            ole_pkg::CMD_POP_FRONT: begin
                if (list_empty) begin
                    dec_st = ole_pkg::STS_EMPTY;
                end else begin
                    dec_op = ole_pkg::OP_DEL;
                end
            end
            ole_pkg::CMD_POP_BACK: begin
                if (list_empty) begin
                    dec_st = ole_pkg::STS_EMPTY;
                end else begin
                    dec_op = ole_pkg::OP_DEL;
                    dec_k  = cnt_m1[IDX_W-1:0];
                end
            end
            ole_pkg::CMD_DELETE_AT: begin
                priority if (s_position == '0) begin
                    dec_st = ole_pkg::STS_INVALID;
                end else if (s_position == 6'd1 && list_empty) begin
                    dec_st = ole_pkg::STS_EMPTY;
                end else if (pos_w > cnt_w) begin
                    dec_st = ole_pkg::STS_RANGE;
                end else begin
                    dec_op = ole_pkg::OP_DEL;
                    dec_k  = pos_m1[IDX_W-1:0];
                end
            end
            ole_pkg::CMD_FIND_VALUE: begin
                if (list_empty) begin
                    dec_st = ole_pkg::STS_EMPTY;
                end else begin
                    dec_op = ole_pkg::OP_FIND;
                end
            end
            ole_pkg::CMD_READ_AT: begin
                priority if (s_position == '0) begin
                    dec_st = ole_pkg::STS_INVALID;
                end else if (pos_w > cnt_w) begin
                    dec_st = ole_pkg::STS_RANGE;
                end else begin
                    dec_op = ole_pkg::OP_READ;
                    dec_k  = pos_m1[IDX_W-1:0];
                end
            end
            ole_pkg::CMD_COUNT: begin
                dec_op = ole_pkg::OP_NONE;
            end
            ole_pkg::CMD_PURGE: begin
                if (list_empty) begin
                    dec_st = ole_pkg::STS_EMPTY;
                end else begin
                    dec_op = ole_pkg::OP_PURGE;
                end
            end
            default: begin
                dec_st = ole_pkg::STS_INVALID;
            end
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ole_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = (dec_op == ole_pkg::OP_NONE) ? ole_pkg::ST_DONE
                                                              : ole_pkg::ST_WALK;
                end
            end
            ole_pkg::ST_WALK: begin
                if (walk_end) begin
                    state_next = (op_reg == ole_pkg::OP_INS) ? ole_pkg::ST_PUT
                                                             : ole_pkg::ST_DONE;
                end
            end
            ole_pkg::ST_PUT: begin
                state_next = ole_pkg::ST_DONE;
            end
            ole_pkg::ST_DONE: begin
                if (out_load) begin
                    state_next = ole_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ole_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and ram control
    always_comb begin
        op_next      = op_reg;
        cnt_next     = cnt_reg;
        val_next     = val_reg;
        k_next       = k_reg;
        cur_next     = cur_reg;
        last_next    = last_reg;
        dn_next      = dn_reg;
        rd_more_next = rd_more_reg;
        p_vld_next   = p_vld_reg;
        p_idx_next   = p_idx_reg;
        w_next       = w_reg;
        hit_next     = hit_reg;
        st_next      = st_reg;
        rv_next      = rv_reg;
        rp_next      = rp_reg;
        wr_en        = 1'b0;
        wr_addr      = '0;
        wr_data      = rd_data;
        rd_en        = 1'b0;

        unique case (state_reg)
            ole_pkg::ST_IDLE: begin
                if (accept) begin
                    op_next      = dec_op;
                    st_next      = dec_st;
                    val_next     = s_value;
                    k_next       = dec_k;
                    rv_next      = '0;
                    rp_next      = '0;
                    hit_next     = 1'b0;
                    w_next       = '0;
                    p_vld_next   = 1'b0;
                    dn_next      = 1'b0;
                    rd_more_next = 1'b0;
                    cur_next     = '0;
                    last_next    = cnt_m1[IDX_W-1:0];
                    unique case (dec_op)
                        ole_pkg::OP_INS: begin
                            // shift tail up one slot, from the last entry down to k
                            rd_more_next = (CNT_W'(dec_k) < cnt_reg);
                            cur_next     = cnt_m1[IDX_W-1:0];
                            last_next    = dec_k;
                            dn_next      = 1'b1;
                        end
                        ole_pkg::OP_DEL: begin
                            rd_more_next = 1'b1;
                            cur_next     = dec_k;
                        end
                        ole_pkg::OP_READ: begin
                            rd_more_next = 1'b1;
                            cur_next     = dec_k;
                            last_next    = dec_k;
                        end
                        ole_pkg::OP_FIND, ole_pkg::OP_PURGE: begin
                            rd_more_next = 1'b1;
                        end
                        default: begin
                            rd_more_next = 1'b0;
                        end
                    endcase
                end
            end

            ole_pkg::ST_WALK: begin
                // read side: one entry a cycle
                if (rd_more_reg) begin
                    rd_en = 1'b1;
                    if (cur_reg == last_reg) begin
                        rd_more_next = 1'b0;
                    end else if (dn_reg) begin
                        cur_next = cur_reg - IDX_W'(1);
                    end else begin
                        cur_next = cur_reg + IDX_W'(1);
                    end
                end
                p_vld_next = rd_more_reg;
                p_idx_next = cur_reg;

                // data side: entry read last cycle
                if (p_vld_reg) begin
                    unique case (op_reg)
                        ole_pkg::OP_INS: begin
                            wr_en   = 1'b1;
                            wr_addr = p_idx_reg + IDX_W'(1);
                        end
                        ole_pkg::OP_DEL: begin
                            if (p_idx_reg == k_reg) begin
                                rv_next = rd_data;
                            end else begin
                                wr_en   = 1'b1;
                                wr_addr = p_idx_reg - IDX_W'(1);
                            end
                        end
                        ole_pkg::OP_READ: begin
                            rv_next = rd_data;
                        end
                        ole_pkg::OP_FIND: begin
                            // first match wins, later reads are dropped
                            if (!hit_reg && rd_data == val_reg) begin
                                hit_next     = 1'b1;
                                rp_next      = CNT_W'(p_idx_reg) + CNT_W'(1);
                                rd_more_next = 1'b0;
                            end
                        end
                        ole_pkg::OP_PURGE: begin
                            // keep non-matching entries, packed from the front
                            if (rd_data != val_reg) begin
                                wr_en   = 1'b1;
                                wr_addr = w_reg[IDX_W-1:0];
                                w_next  = w_reg + CNT_W'(1);
                            end
                        end
                        default: begin
                            wr_en = 1'b0;
                        end
                    endcase
                end

                // closing updates once the walk has drained
                if (walk_end) begin
                    unique case (op_reg)
                        ole_pkg::OP_DEL: begin
                            cnt_next = cnt_m1;
                        end
                        ole_pkg::OP_READ: begin
                            rp_next = CNT_W'(k_reg) + CNT_W'(1);
                        end
                        ole_pkg::OP_FIND: begin
                            if (!hit_reg) begin
                                st_next = ole_pkg::STS_NOTFOUND;
                            end
                        end
                        ole_pkg::OP_PURGE: begin
                            rp_next  = cnt_reg - w_reg;
                            cnt_next = w_reg;
                            if (cnt_reg == w_reg) begin
                                st_next = ole_pkg::STS_NOTFOUND;
                            end
                        end
                        default: begin
                            cnt_next = cnt_reg;
                        end
                    endcase
                end
            end

            ole_pkg::ST_PUT: begin
                // new value lands in the freed slot
                wr_en    = 1'b1;
                wr_addr  = k_reg;
                wr_data  = val_reg;
                cnt_next = cnt_reg + CNT_W'(1);
            end

            ole_pkg::ST_DONE: begin
                p_vld_next = 1'b0;
            end

            default: begin
                p_vld_next = 1'b0;
            end
        endcase
    end

    // result register, low six bits of position and count
    assign rp_ext  = {6'b0, rp_reg};
    assign cnt_ext = {6'b0, cnt_reg};

    always_comb begin
        m_status_next = m_status_reg;
        m_value_next  = m_value_reg;
        m_pos_next    = m_pos_reg;
        m_cnt_next    = m_cnt_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_status_next = st_reg;
            m_value_next  = rv_reg;
            m_pos_next    = rp_ext[5:0];
            m_cnt_next    = cnt_ext[5:0];
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ole_pkg::ST_IDLE;
            cnt_reg     <= '0;
            rd_more_reg <= 1'b0;
            p_vld_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rd_more_reg <= rd_more_next;
            p_vld_reg   <= p_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        k_reg        <= k_next;
        cur_reg      <= cur_next;
        last_reg     <= last_next;
        dn_reg       <= dn_next;
        p_idx_reg    <= p_idx_next;
        w_reg        <= w_next;
        hit_reg      <= hit_next;
        st_reg       <= st_next;
        rv_reg       <= rv_next;
        rp_reg       <= rp_next;
        m_status_reg <= m_status_next;
        m_value_reg  <= m_value_next;
        m_pos_reg    <= m_pos_next;
        m_cnt_reg    <= m_cnt_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_result_value    = m_value_reg;
    assign m_result_position = m_pos_reg;
    assign m_entry_count     = m_cnt_reg;

endmodule

/* rtl/ole_mem.sv */
module ole_mem #(
    parameter int DEPTH = ole_pkg::CAPACITY_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] store_reg [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_reg[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sim/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ole_pkg::*;

    localparam int DEPTH         = CAPACITY_DEFAULT;
    localparam int RANDOM_ITEMS  = 1750;
    localparam int SETTLE_CYCLES = DEPTH + 16;
    localparam int CYCLE_LIMIT   = 1500000;

    // stimulus moods, chosen per segment of random commands
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIXED = 2;

    typedef struct packed {
        logic [3:0]         command;
        logic signed [31:0] value;
        logic [5:0]         position;
        logic               hold;      // wait for every result before presenting
    } list_cmd_t;

    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value;
        logic [5:0]         position;
        logic [5:0]         count;
    } list_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [3:0]         s_command = CMD_COUNT;
    logic signed [31:0] s_value = '0;
    logic [5:0]         s_position = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [2:0]         m_status;
    logic signed [31:0] m_result_value;
    logic [5:0]         m_result_position;
    logic [5:0]         m_entry_count;

    // commands waiting to be driven, and results still owed by the block
    list_cmd_t    pending_cmds[$];
    list_result_t results_due[$];
    list_cmd_t    driven_cmd;
    list_result_t arrived_want;

    // shadow copy of the list contents
    logic signed [31:0] shadow_entries [DEPTH];
    int                 shadow_count = 0;
    int                 peak_count = 0;

    int idle_pct = 0;
    int stall_pct = 0;
    int planned_depth = 0;
    int mismatch_count = 0;
    int commands_accepted = 0;
    int results_checked = 0;
    int cycle_count = 0;
    int status_seen [8];

    ordered_list_engine_core #(
        .CAPACITY(DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_value           (s_value),
        .s_position        (s_position),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_result_value    (m_result_value),
        .m_result_position (m_result_position),
        .m_entry_count     (m_entry_count)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // list predictor
    // ---------------------------------------------------------------

    // open a gap at slot and store v there, entries behind move back one place
    function automatic void shadow_insert(input int slot, input logic signed [31:0] v);
        int i;
        for (i = shadow_count; i > slot; i--)
            shadow_entries[i] = shadow_entries[i - 1];
        shadow_entries[slot] = v;
        shadow_count++;
        if (shadow_count > peak_count)
            peak_count = shadow_count;
    endfunction

    // close the gap left by slot and hand back what it held
    function automatic logic signed [31:0] shadow_remove(input int slot);
        logic signed [31:0] v;
        int i;
        v = shadow_entries[slot];
        for (i = slot; i + 1 < shadow_count; i++)
            shadow_entries[i] = shadow_entries[i + 1];
        shadow_count--;
        return v;
    endfunction

    function automatic list_result_t apply_list_command(input list_cmd_t c);
        list_result_t r;
        int i;
        int kept;
        int pos;
        r = '0;
        pos = c.position;
        case (c.command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (shadow_count >= DEPTH)
                    r.status = STS_FULL;
                else
                    shadow_insert((c.command == CMD_PUSH_FRONT) ? 0 : shadow_count, c.value);
            end
            CMD_INSERT_AT: begin
                if (pos == 0)
                    r.status = STS_INVALID;
                else if (pos > shadow_count + 1)
                    r.status = STS_RANGE;
                else if (shadow_count >= DEPTH)
                    r.status = STS_FULL;
                else
                    shadow_insert(pos - 1, c.value);
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (shadow_count == 0)
                    r.status = STS_EMPTY;
                else
                    r.value = shadow_remove((c.command == CMD_POP_FRONT) ? 0 : shadow_count - 1);
            end
            CMD_DELETE_AT: begin
                if (pos == 0)
                    r.status = STS_INVALID;
                else if (pos == 1 && shadow_count == 0)
                    r.status = STS_EMPTY;
                else if (pos > shadow_count)
                    r.status = STS_RANGE;
                else
                    r.value = shadow_remove(pos - 1);
            end
            CMD_FIND_VALUE: begin
                if (shadow_count == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    r.status = STS_NOTFOUND;
                    for (i = 0; i < shadow_count && r.status != STS_OK; i++) begin
                        if (shadow_entries[i] == c.value) begin
                            r.status   = STS_OK;
                            r.position = 6'(i + 1);
                        end
                    end
                end
            end
            CMD_READ_AT: begin
                if (pos == 0)
                    r.status = STS_INVALID;
                else if (pos > shadow_count)
                    r.status = STS_RANGE;
                else begin
                    r.value    = shadow_entries[pos - 1];
                    r.position = c.position;
                end
            end
            CMD_COUNT: begin
            end
            CMD_PURGE: begin
                if (shadow_count == 0) begin
                    r.status = STS_EMPTY;
                end else begin
                    // compact the survivors towards the front
                    kept = 0;
                    for (i = 0; i < shadow_count; i++) begin
                        if (shadow_entries[i] != c.value) begin
                            shadow_entries[kept] = shadow_entries[i];
                            kept++;
                        end
                    end
                    r.position   = 6'(shadow_count - kept);
                    shadow_count = kept;
                    if (r.position == 0)
                        r.status = STS_NOTFOUND;
                end
            end
            default: r.status = STS_INVALID;
        endcase
        r.count = 6'(shadow_count);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------

    task automatic add_cmd(input logic [3:0] cmd, input logic signed [31:0] v,
                           input logic [5:0] pos);
        list_cmd_t c;
        c.command  = cmd;
        c.value    = v;
        c.position = pos;
        c.hold     = 1'b0;
        pending_cmds.push_back(c);
    endtask

    function automatic logic [3:0] pick_command(input int mode);
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return 4'($urandom_range(10, 15));
        if (mode == MODE_FILL) begin
            if (r < 35) return CMD_PUSH_FRONT;
            if (r < 65) return CMD_PUSH_BACK;
            if (r < 88) return CMD_INSERT_AT;
        end else if (mode == MODE_DRAIN) begin
            if (r < 25) return CMD_POP_FRONT;
            if (r < 45) return CMD_POP_BACK;
            if (r < 70) return CMD_DELETE_AT;
            if (r < 80) return CMD_PURGE;
        end
        return 4'($urandom_range(0, 9));
    endfunction

    // a small pool of values makes finds and purges hit, duplicates included
    function automatic logic signed [31:0] pick_value(input bit want_match);
        if ($urandom_range(99) >= (want_match ? 85 : 55))
            return $urandom;
        case ($urandom_range(0, 7))
            0: return 32'sh0000_0000;
            1: return 32'sh0000_0001;
            2: return -32'sd1;
            3: return 32'sh7fff_ffff;
            4: return 32'sh8000_0000;
            5: return 32'sh5a5a_5a5a;
            6: return 32'sd42;
            default: return -32'sd42;
        endcase
    endfunction

    function automatic logic [5:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (r < 6)
            return 6'd0;
        if (r < 16)
            return 6'($urandom_range(0, 63));
        return 6'($urandom_range(1, planned_depth + 2));
    endfunction

    task automatic queue_random_cmds(input int n);
        list_cmd_t c;
        int k;
        int seg_left;
        int mode;
        seg_left = 0;
        mode = MODE_MIXED;
        // list is settled here, so the estimate starts exact
        planned_depth = shadow_count;
        for (k = 0; k < n; k++) begin
            if (seg_left == 0) begin
                mode     = $urandom_range(MODE_FILL, MODE_MIXED);
                seg_left = $urandom_range(16, 48);
            end
            seg_left--;
            c.command  = pick_command(mode);
            c.value    = pick_value(c.command == CMD_FIND_VALUE || c.command == CMD_PURGE);
            c.position = pick_position();
            // first command of a batch, and a few others, let the list settle first
            c.hold     = (k == 0) || ($urandom_range(99) == 0);
            // rough depth estimate that keeps positions near the live range
            case (c.command)
                CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_INSERT_AT:
                    if (planned_depth < DEPTH) planned_depth++;
                CMD_POP_FRONT, CMD_POP_BACK, CMD_DELETE_AT:
                    if (planned_depth > 0) planned_depth--;
                CMD_PURGE:
                    planned_depth = planned_depth / 2;
                default: begin
                end
            endcase
            pending_cmds.push_back(c);
        end
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0 || s_valid || results_due.size() != 0)
            @(posedge aclk);
    endtask

    task automatic run_phase(input int idle, input int stall, input int n);
        idle_pct  = idle;
        stall_pct = stall;
        queue_random_cmds(n);
        wait_drained();
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
        end
    endtask

    // ---------------------------------------------------------------
    // command driver: presents queued commands, predicts on acceptance
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                results_due.push_back(apply_list_command(driven_cmd));
                commands_accepted++;
            end
            // free to present something new only when the bus holds nothing pending
            if (!s_valid || s_ready) begin
                if (pending_cmds.size() != 0
                        && !(pending_cmds[0].hold && results_due.size() != 0)
                        && $urandom_range(99) >= idle_pct) begin
                    driven_cmd = pending_cmds.pop_front();
                    s_command  <= driven_cmd.command;
                    s_value    <= driven_cmd.value;
                    s_position <= driven_cmd.position;
                    s_valid    <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // result monitor: compares each transaction with the oldest prediction
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (results_due.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: result with nothing expected, status %0d value %0h",
                             $time, m_status, m_result_value);
                end else begin
                    arrived_want = results_due.pop_front();
                    check_field("status", 32'(arrived_want.status), 32'(m_status));
                    check_field("result_value", arrived_want.value, m_result_value);
                    check_field("result_position", 32'(arrived_want.position),
                                32'(m_result_position));
                    check_field("entry_count", 32'(arrived_want.count), 32'(m_entry_count));
                    results_checked++;
                    status_seen[m_status]++;
                end
            end
            m_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still owed", $time, results_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        foreach (status_seen[i])
            status_seen[i] = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // every empty-list corner
        add_cmd(CMD_POP_FRONT,  32'sd0, 6'd0);
        add_cmd(CMD_POP_BACK,   32'sd0, 6'd0);
        add_cmd(CMD_DELETE_AT,  32'sd0, 6'd0);
        add_cmd(CMD_DELETE_AT,  32'sd0, 6'd1);
        add_cmd(CMD_DELETE_AT,  32'sd0, 6'd2);
        add_cmd(CMD_FIND_VALUE, 32'sd5, 6'd0);
        add_cmd(CMD_PURGE,      32'sd5, 6'd0);
        add_cmd(CMD_READ_AT,    32'sd0, 6'd0);
        add_cmd(CMD_READ_AT,    32'sd0, 6'd1);
        add_cmd(CMD_INSERT_AT,  32'sd9, 6'd0);
        add_cmd(CMD_INSERT_AT,  32'sd9, 6'd2);
        // build a short list, with a middle insert
        add_cmd(CMD_INSERT_AT,  32'sh7fff_ffff, 6'd1);
        add_cmd(CMD_PUSH_FRONT, 32'sh8000_0000, 6'd0);
        add_cmd(CMD_PUSH_BACK,  -32'sd1, 6'd0);
        add_cmd(CMD_INSERT_AT,  32'sd0, 6'd2);
        add_cmd(CMD_INSERT_AT,  32'sd7, 6'd63);
        add_cmd(CMD_READ_AT,    32'sd0, 6'd3);
        add_cmd(CMD_FIND_VALUE, -32'sd1, 6'd0);
        add_cmd(CMD_FIND_VALUE, 32'sd12345, 6'd0);
        add_cmd(CMD_COUNT,      32'sd0, 6'd0);
        add_cmd(4'd15,          32'sd0, 6'd0);
        add_cmd(4'd10,          32'sd0, 6'd0);
        // purge with a duplicate, then empty the list again
        add_cmd(CMD_PUSH_BACK,  -32'sd1, 6'd0);
        add_cmd(CMD_PURGE,      -32'sd1, 6'd0);
        add_cmd(CMD_DELETE_AT,  32'sd0, 6'd2);
        add_cmd(CMD_POP_BACK,   32'sd0, 6'd0);
        add_cmd(CMD_POP_FRONT,  32'sd0, 6'd0);
        wait_drained();

        // handshake phases: free flow, sparse sender, slow receiver, both
        run_phase(0, 0, RANDOM_ITEMS / 4);
        run_phase(82, 0, RANDOM_ITEMS / 4);
        run_phase(0, 82, RANDOM_ITEMS / 4);
        run_phase(22, 22, RANDOM_ITEMS / 4);

        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("covered %0d commands under four flow-control mixes, %0d results, peak depth %0d",
                 commands_accepted, results_checked, peak_count);
        $display("status mix: ok %0d empty %0d invalid %0d range %0d notfound %0d full %0d",
                 status_seen[STS_OK], status_seen[STS_EMPTY], status_seen[STS_INVALID],
                 status_seen[STS_RANGE], status_seen[STS_NOTFOUND], status_seen[STS_FULL]);
        if (mismatch_count == 0 && results_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count, results_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/ole_pkg.sv
rtl/ole_mem.sv
rtl/ordered_list_engine_core.sv
sim/tb_top.sv
